// ===== rtl/ppd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ppd_pkg
// Types and constants for the point-to-plane distance pipeline.
// ---------------------------------------------------------------------------
package ppd_pkg;

    localparam int ROOT_BITS = 32;
    localparam int N_PRE     = 5;
    localparam int N_STAGES  = N_PRE + ROOT_BITS + 1;

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_COEF_D = 2'd3;

    localparam logic [31:0] COEF_A_RST = 32'h0001_0000;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAG    = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               keep_sign;
    } t_in;

    typedef struct packed {
        logic signed [31:0] distance;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic signed [63:0] ax;
        logic signed [63:0] by;
        logic signed [63:0] cz;
        logic signed [63:0] d16;
        logic [63:0]        aa;
        logic [63:0]        bb;
        logic [63:0]        cc;
        logic               keep;
        logic               deg;
    } t_s1;

    typedef struct packed {
        logic signed [65:0] p;
        logic [63:0]        q;
        logic               keep;
        logic               deg;
    } t_s2;

    typedef struct packed {
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        logic        keep;
        logic        deg;
    } t_s3;

    typedef struct packed {
        logic [63:0] hh;
        logic [63:0] hl;
        logic [63:0] ll;
        logic [63:0] q;
        logic        neg;
        logic        keep;
        logic        deg;
    } t_s4;

    typedef struct packed {
        logic [63:0]  q;
        logic [127:0] rem;
        logic [95:0]  s;
        logic [31:0]  m;
        logic         neg;
        logic         keep;
        logic         deg;
    } t_rt;

endpackage
`default_nettype wire

// ===== rtl/point_plane_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 5 arithmetic stages, 32 root stages (one result bit each) and
// the output register, between item accept and o_out_valid.
// Throughput: one item per cycle while the output is not stalled; stages
// advance independently, so bubbles close up while the output is stalled.
// Reset: synchronous active-low; clears valid bits and loads the plane
// registers with A = 1.0, B = C = D = 0.
// ---------------------------------------------------------------------------
// point_plane_distance
// Signed Q16.16 distance of streamed points to a configured plane, using an
// exact bit-by-bit search for floor(|P| / sqrt(Q)).
// ---------------------------------------------------------------------------
module point_plane_distance (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire ppd_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output ppd_pkg::t_out     o_out_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int NST = ppd_pkg::N_STAGES;
    localparam int RB  = ppd_pkg::ROOT_BITS;
    localparam int NP  = ppd_pkg::N_PRE;

    logic signed [31:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= ppd_pkg::COEF_A_RST;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppd_pkg::REG_COEF_A: r_coef_a <= i_cfg_data;
                ppd_pkg::REG_COEF_B: r_coef_b <= i_cfg_data;
                ppd_pkg::REG_COEF_C: r_coef_c <= i_cfg_data;
                ppd_pkg::REG_COEF_D: r_coef_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain, each stage loads when empty or when its successor moves
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_adv;

    always_comb begin
        w_adv[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_adv[i] = !r_v[i] || w_adv[i+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // stage 1: products
    ppd_pkg::t_s1 r_s1, n_s1;
    always_comb begin
        n_s1.ax   = r_coef_a * i_in_data.point_x;
        n_s1.by   = r_coef_b * i_in_data.point_y;
        n_s1.cz   = r_coef_c * i_in_data.point_z;
        n_s1.d16  = {{16{r_coef_d[31]}}, r_coef_d, 16'h0000};
        n_s1.aa   = r_coef_a * r_coef_a;
        n_s1.bb   = r_coef_b * r_coef_b;
        n_s1.cc   = r_coef_c * r_coef_c;
        n_s1.keep = i_in_data.keep_sign;
        n_s1.deg  = (r_coef_a == '0) && (r_coef_b == '0) && (r_coef_c == '0);
    end

    // stage 2: sums
    ppd_pkg::t_s2 r_s2, n_s2;
    always_comb begin
        n_s2.p    = 66'(r_s1.ax) + 66'(r_s1.by) + 66'(r_s1.cz) + 66'(r_s1.d16);
        n_s2.q    = r_s1.aa + r_s1.bb + r_s1.cc;
        n_s2.keep = r_s1.keep;
        n_s2.deg  = r_s1.deg;
    end

    // stage 3: magnitude (|P| < 2^64)
    ppd_pkg::t_s3 r_s3, n_s3;
    always_comb begin
        n_s3.neg  = r_s2.p[65];
        n_s3.mag  = r_s2.p[65] ? 64'(-r_s2.p) : r_s2.p[63:0];
        n_s3.q    = r_s2.q;
        n_s3.keep = r_s2.keep;
        n_s3.deg  = r_s2.deg;
    end

    // stage 4: partial products of |P|^2
    ppd_pkg::t_s4 r_s4, n_s4;
    always_comb begin
        n_s4.hh   = r_s3.mag[63:32] * r_s3.mag[63:32];
        n_s4.hl   = r_s3.mag[63:32] * r_s3.mag[31:0];
        n_s4.ll   = r_s3.mag[31:0] * r_s3.mag[31:0];
        n_s4.q    = r_s3.q;
        n_s4.neg  = r_s3.neg;
        n_s4.keep = r_s3.keep;
        n_s4.deg  = r_s3.deg;
    end

    // stage 5: P^2 seeds the root search; rem = P^2 - m^2*Q, s = m*Q
    ppd_pkg::t_rt r_rt [0:RB];
    ppd_pkg::t_rt n_rt0;
    always_comb begin
        n_rt0.rem  = {r_s4.hh, 64'h0} + {31'h0, r_s4.hl, 33'h0} + {64'h0, r_s4.ll};
        n_rt0.s    = '0;
        n_rt0.m    = '0;
        n_rt0.q    = r_s4.q;
        n_rt0.neg  = r_s4.neg;
        n_rt0.keep = r_s4.keep;
        n_rt0.deg  = r_s4.deg;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) r_s1 <= n_s1;
        if (w_adv[1]) r_s2 <= n_s2;
        if (w_adv[2]) r_s3 <= n_s3;
        if (w_adv[3]) r_s4 <= n_s4;
        if (w_adv[4]) r_rt[0] <= n_rt0;
    end

    // root stages: try bit k; (m+2^k)^2 Q - m^2 Q = 2^(k+1) s + 2^(2k) Q
    for (genvar j = 1; j <= RB; j++) begin : g_root
        localparam int K = RB - j;
        logic [129:0]  w_cand;
        logic          w_fit;
        ppd_pkg::t_rt  n_rt;
        always_comb begin
            w_cand = ({34'h0, r_rt[j-1].s} << (K + 1)) + ({66'h0, r_rt[j-1].q} << (2 * K));
            w_fit  = w_cand <= {2'b00, r_rt[j-1].rem};
            n_rt   = r_rt[j-1];
            if (w_fit) begin
                n_rt.rem  = r_rt[j-1].rem - w_cand[127:0];
                n_rt.s    = r_rt[j-1].s + ({32'h0, r_rt[j-1].q} << K);
                n_rt.m[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[NP - 1 + j]) r_rt[j] <= n_rt;
        end
    end

    // output stage: zero for a degenerate plane, else sign and saturation
    ppd_pkg::t_out r_out, n_out;
    always_comb begin
        n_out.degenerate = r_rt[RB].deg;
        if (r_rt[RB].deg) begin
            n_out.distance = '0;
        end else if (r_rt[RB].neg && r_rt[RB].keep) begin
            n_out.distance = (r_rt[RB].m > ppd_pkg::NEG_MAG) ? ppd_pkg::NEG_MAG
                                                              : -r_rt[RB].m;
        end else begin
            n_out.distance = (r_rt[RB].m > ppd_pkg::POS_MAX) ? ppd_pkg::POS_MAX
                                                              : r_rt[RB].m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) r_out <= n_out;
    end

    assign o_out_data = r_out;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |-> o_out_data.distance == '0)
        else $error("degenerate result with nonzero distance");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v[0])
        else $error("accepted item did not enter first stage");

    a_q_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NP-1] |-> ((r_rt[0].q == '0) == r_rt[0].deg))
        else $error("norm square disagrees with degenerate flag");

endmodule
`default_nettype wire
